[hdl/pkm_pkg.sv]
// shared types, dictionary roms and rom unpacking functions for the keyword prefix matcher
`default_nettype none

package pkm_pkg;

	// default sizes
	localparam int MAX_ENTRIES_DEF   = 16;
	localparam int MAX_TOKEN_LEN_DEF = 32;

	// text positions that a 5-bit index can address, and packed text width
	localparam int TXT_POS = 32;
	localparam int TXT_W   = TXT_POS * 5;

	// table select codes
	localparam logic SEL_CMD = 1'b0;
	localparam logic SEL_DIR = 1'b1;

	// register word index of table_select
	localparam logic REG_TABLE_SELECT = 1'b0;

	// error code for the index and id fields
	localparam logic [7:0] ERR_CODE = 8'hFF;

	// status codes
	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	localparam int CMD_ROM_LEN = 69;
	localparam int DIR_ROM_LEN = 26;

	localparam logic [7:0] CMD_ROM [CMD_ROM_LEN] = '{
		8'h0F, 8'h30, 8'h03, 8'h4A, 8'h04, 8'h6B, 8'h28, 8'h06, 8'hC4, 8'hB4, 8'h40, 8'h20,
		8'h09, 8'h27, 8'hC0, 8'h38, 8'h0B, 8'h80, 8'hB5, 8'h2E, 8'h28, 8'h18, 8'h0E, 8'h5A,
		8'h00, 8'h30, 8'h12, 8'hE1, 8'h85, 8'hD4, 8'h20, 8'h18, 8'hF7, 8'hAC, 8'h20, 8'h1A,
		8'hFB, 8'h14, 8'h20, 8'h21, 8'h56, 8'h30, 8'h30, 8'h24, 8'h5B, 8'h14, 8'h2C, 8'h20,
		8'h27, 8'h47, 8'hDC, 8'h20, 8'h29, 8'h59, 8'h38, 8'h18, 8'h2B, 8'h32, 8'h80, 8'h28,
		8'h34, 8'hC7, 8'h84, 8'h80, 8'h28, 8'h35, 8'h30, 8'hD8, 8'hA0
	};

	localparam logic [7:0] DIR_ROM [DIR_ROM_LEN] = '{
		8'h06, 8'h20, 8'h18, 8'h53, 8'h50, 8'h28, 8'h24, 8'h93, 8'hA2, 8'h80, 8'h20, 8'h04,
		8'h11, 8'hAC, 8'h30, 8'h03, 8'h27, 8'hD5, 8'hC4, 8'h10, 8'h2B, 8'h00, 8'h20, 8'h08,
		8'hFB, 8'hB8
	};

	// result beat handed from the matcher core to the output register
	typedef struct packed {
		logic       status;
		logic [7:0] index;
		logic [7:0] id;
	} res_t;

	// byte of the selected rom, zero past its end
	function automatic logic [7:0] rom_byte(input logic sel, input int idx);
		logic [7:0] b;
		b = 8'h00;
		if (sel == SEL_DIR) begin
			if (idx < DIR_ROM_LEN) b = DIR_ROM[idx];
		end else begin
			if (idx < CMD_ROM_LEN) b = CMD_ROM[idx];
		end
		return b;
	endfunction

	// 5-bit group at an msb-first bit position
	function automatic logic [4:0] rom_five(input logic sel, input int bitpos);
		int          byte_idx;
		logic [15:0] word;
		logic [15:0] sh;
		byte_idx = bitpos >> 3;
		word = {rom_byte(sel, byte_idx), rom_byte(sel, byte_idx + 1)};
		sh = word >> (11 - (bitpos & 7));
		return sh[4:0];
	endfunction

	// byte offset of an entry, walking the packed entries before it
	function automatic int entry_offset(input logic sel, input int e);
		int         offset;
		logic [4:0] len;
		offset = 1;
		for (int k = 0; k < e; k++) begin
			len = rom_five(sel, offset * 8);
			offset = offset + ((5 * (int'(len) + 2) + 7) >> 3);
		end
		return offset;
	endfunction

	function automatic logic [4:0] entry_len(input logic sel, input int e);
		return rom_five(sel, entry_offset(sel, e) * 8);
	endfunction

	function automatic logic [4:0] entry_id(input logic sel, input int e);
		return rom_five(sel, entry_offset(sel, e) * 8 + 5);
	endfunction

	// all text characters of an entry, position p at bits [p*5 +: 5]
	function automatic logic [TXT_W-1:0] entry_text(input logic sel, input int e);
		logic [TXT_W-1:0] t;
		int               base;
		t = '0;
		base = entry_offset(sel, e) * 8 + 10;
		for (int p = 0; p < TXT_POS; p++) begin
			t[p*5 +: 5] = rom_five(sel, base + 5 * p);
		end
		return t;
	endfunction

	// entry exists in the selected rom
	function automatic logic entry_present(input logic sel, input int e);
		return (e < int'(rom_byte(sel, 0)));
	endfunction

endpackage

`default_nettype wire

[hdl/packed_keyword_prefix_matcher_top.sv]
// top level: apb register, input register, matcher core and result register
// path: a last character passes the input register, then the result register, to the output
// throughput: one character per cycle while unstalled, set by the combinational lane compare
// a stalled result blocks input only once the next last character sits in the input register
// reset: asynchronous, table_select clears to the command table, token state to empty
`default_nettype none

module packed_keyword_prefix_matcher_top #(
	parameter int MAX_ENTRIES   = pkm_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_TOKEN_LEN = pkm_pkg::MAX_TOKEN_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// character channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             status,
	output logic [7:0]       entry_index,
	output logic [7:0]       entry_id
);

	logic          sel_q;
	logic          cfg_wr;
	logic          s1_valid;
	logic [7:0]    char_s1;
	logic          last_s1;
	logic          s1_adv;
	logic          in_acc;
	logic          res_load;
	pkm_pkg::res_t res;
	pkm_pkg::res_t res_q;
	logic          out_valid_q;

	// register write and readback
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == pkm_pkg::REG_TABLE_SELECT);
	assign prdata = (paddr[2] == pkm_pkg::REG_TABLE_SELECT) ? {31'b0, sel_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= pkm_pkg::SEL_CMD;
		end else if (cfg_wr) begin
			sel_q <= pwdata[0];
		end
	end

	// s1 moves on unless it holds a last character and the result register is blocked
	assign s1_adv   = s1_valid && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = s1_valid && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign res_load = s1_adv && last_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= in_acc || (s1_valid && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	pkm_core #(
		.MAX_ENTRIES   (MAX_ENTRIES),
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_adv),
		.char_code (char_s1),
		.last_char (last_s1),
		.sel       (sel_q),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= res_load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign status      = res_q.status;
	assign entry_index = res_q.index;
	assign entry_id    = res_q.id;

endmodule

`default_nettype wire

[hdl/pkm_lane.sv]
// one dictionary entry: constant length, id and text columns, compare against one character
`default_nettype none

module pkm_lane #(
	parameter int ENTRY         = 0,
	parameter int MAX_TOKEN_LEN = pkm_pkg::MAX_TOKEN_LEN_DEF,
	parameter int PW            = $clog2(MAX_TOKEN_LEN)
) (
	input  wire logic          sel,
	input  wire logic [PW-1:0] pos_idx,
	input  wire logic [7:0]    char_code,
	output logic               present,
	output logic               hit,
	output logic [4:0]         id
);

	localparam logic [4:0]                LEN0  = pkm_pkg::entry_len(pkm_pkg::SEL_CMD, ENTRY);
	localparam logic [4:0]                LEN1  = pkm_pkg::entry_len(pkm_pkg::SEL_DIR, ENTRY);
	localparam logic [4:0]                ID0   = pkm_pkg::entry_id(pkm_pkg::SEL_CMD, ENTRY);
	localparam logic [4:0]                ID1   = pkm_pkg::entry_id(pkm_pkg::SEL_DIR, ENTRY);
	localparam logic [pkm_pkg::TXT_W-1:0] TEXT0 = pkm_pkg::entry_text(pkm_pkg::SEL_CMD, ENTRY);
	localparam logic [pkm_pkg::TXT_W-1:0] TEXT1 = pkm_pkg::entry_text(pkm_pkg::SEL_DIR, ENTRY);
	localparam logic                      PRES0 = pkm_pkg::entry_present(pkm_pkg::SEL_CMD, ENTRY);
	localparam logic                      PRES1 = pkm_pkg::entry_present(pkm_pkg::SEL_DIR, ENTRY);

	logic [4:0] len;
	logic [4:0] text_char;
	logic [5:0] pos_ext;

	// column lookup for the selected table
	always_comb begin
		if (sel == pkm_pkg::SEL_DIR) begin
			len       = LEN1;
			id        = ID1;
			present   = PRES1;
			text_char = TEXT1[pos_idx*5 +: 5];
		end else begin
			len       = LEN0;
			id        = ID0;
			present   = PRES0;
			text_char = TEXT0[pos_idx*5 +: 5];
		end
	end

	// character matches when still inside the text and codes agree literally
	assign pos_ext = {{(6-PW){1'b0}}, pos_idx};
	assign hit     = (pos_ext < {1'b0, len}) && (char_code == {3'b000, text_char});

endmodule

`default_nettype wire

[hdl/pkm_core.sv]
// live-entry set, character position and unique-match resolution
`default_nettype none

module pkm_core #(
	parameter int MAX_ENTRIES   = pkm_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_TOKEN_LEN = pkm_pkg::MAX_TOKEN_LEN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    char_code,
	input  wire logic          last_char,
	input  wire logic          sel,
	output pkm_pkg::res_t      res
);

	localparam int PW  = $clog2(MAX_TOKEN_LEN);
	localparam int CW  = $clog2(MAX_TOKEN_LEN + 1);
	localparam int EW  = $clog2(MAX_ENTRIES);
	localparam logic [CW-1:0] POS_SAT = CW'(MAX_TOKEN_LEN);

	logic [MAX_ENTRIES-1:0] alive_q;
	logic [CW-1:0]          pos_q;
	logic [MAX_ENTRIES-1:0] present;
	logic [MAX_ENTRIES-1:0] hit;
	logic [4:0]             lane_id [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0] alive_nxt;
	logic [MAX_ENTRIES-1:0] counted;
	logic                   in_range;
	logic                   unique_hit;
	logic [EW-1:0]          first_idx;
	logic [4:0]             first_id;

	assign in_range = (pos_q < POS_SAT);

	// one compare lane per entry
	for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_lane
		pkm_lane #(
			.ENTRY         (e),
			.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
			.PW            (PW)
		) u_lane (
			.sel       (sel),
			.pos_idx   (pos_q[PW-1:0]),
			.char_code (char_code),
			.present   (present[e]),
			.hit       (hit[e]),
			.id        (lane_id[e])
		);
	end

	// a miss clears the live bit; entries outside the selected table, or past the last position, keep it
	always_comb begin
		for (int e = 0; e < MAX_ENTRIES; e++) begin
			if (in_range && present[e]) alive_nxt[e] = alive_q[e] & hit[e];
			else alive_nxt[e] = alive_q[e];
		end
	end

	assign counted    = alive_nxt & present;
	assign unique_hit = (counted != '0) && ((counted & (counted - 1'b1)) == '0);

	// lowest live entry
	always_comb begin
		first_idx = '0;
		first_id  = '0;
		for (int e = MAX_ENTRIES - 1; e >= 0; e--) begin
			if (counted[e]) begin
				first_idx = EW'(e);
				first_id  = lane_id[e];
			end
		end
	end

	// result beat, taken only on the last character
	always_comb begin
		if (unique_hit) begin
			res.status = pkm_pkg::ST_OK;
			res.index  = {{(8-EW){1'b0}}, first_idx};
			res.id     = {3'b000, first_id};
		end else begin
			res.status = pkm_pkg::ST_ERR;
			res.index  = pkm_pkg::ERR_CODE;
			res.id     = pkm_pkg::ERR_CODE;
		end
	end

	// token state, back to reset after each last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			pos_q   <= '0;
		end else if (step) begin
			if (last_char) begin
				alive_q <= '1;
				pos_q   <= '0;
			end else begin
				alive_q <= alive_nxt;
				if (in_range) pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the keyword prefix matcher: directed token table, then random tokens
module tb_top;

	localparam int MAX_ENT       = 16;
	localparam int MAX_TOK       = 32;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_CHARS   = 440;
	localparam int REPORT_CAP    = 40;

	// register addresses: table_select and one index past the register map
	localparam logic [2:0] SEL_ADDR = {pkm_pkg::REG_TABLE_SELECT, 2'b00};
	localparam logic [2:0] BAD_ADDR = 3'd4;

	localparam pkm_pkg::res_t ERR_BEAT = '{pkm_pkg::ST_ERR, pkm_pkg::ERR_CODE, pkm_pkg::ERR_CODE};
	localparam pkm_pkg::res_t NO_BEAT  = '0;

	typedef enum logic [1:0] {ROW_CHAR, ROW_CFG, ROW_BADCFG} row_kind_e;

	typedef struct packed {
		row_kind_e     kind;
		logic [7:0]    code;
		logic          lst;
		logic          typed;
		pkm_pkg::res_t want;
	} stim_row_t;

	// directed rows; typed results only where the answer is obvious
	localparam stim_row_t DIRECTED [24] = '{
		// all-ones code and the first code past the 5-bit range never match
		'{ROW_CHAR,   8'd255, 1'b1, 1'b1, ERR_BEAT},
		'{ROW_CHAR,   8'd32,  1'b1, 1'b1, ERR_BEAT},
		// zero code, compared literally
		'{ROW_CHAR,   8'd0,   1'b1, 1'b0, NO_BEAT},
		// a full command word, then a one-letter prefix
		'{ROW_CHAR,   8'd1,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd20,  1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd20,  1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd1,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd3,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd11,  1'b1, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd1,   1'b1, 1'b0, NO_BEAT},
		// dead token stays dead
		'{ROW_CHAR,   8'd254, 1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd1,   1'b1, 1'b1, ERR_BEAT},
		// direction table
		'{ROW_CFG,    8'd1,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd254, 1'b1, 1'b1, ERR_BEAT},
		'{ROW_CHAR,   8'd12,  1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd5,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd6,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd20,  1'b1, 1'b0, NO_BEAT},
		// write past the register map leaves the direction table selected
		'{ROW_BADCFG, 8'd0,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd12,  1'b1, 1'b0, NO_BEAT},
		// table switched in the middle of a token
		'{ROW_CHAR,   8'd12,  1'b0, 1'b0, NO_BEAT},
		'{ROW_CFG,    8'd0,   1'b0, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd9,   1'b1, 1'b0, NO_BEAT},
		'{ROW_CHAR,   8'd31,  1'b1, 1'b0, NO_BEAT}
	};

	// dictionary images, kept apart from the design's copy
	logic [7:0] cmd_bytes [pkm_pkg::CMD_ROM_LEN] = '{
		8'h0F, 8'h30, 8'h03, 8'h4A, 8'h04, 8'h6B, 8'h28, 8'h06, 8'hC4, 8'hB4, 8'h40, 8'h20,
		8'h09, 8'h27, 8'hC0, 8'h38, 8'h0B, 8'h80, 8'hB5, 8'h2E, 8'h28, 8'h18, 8'h0E, 8'h5A,
		8'h00, 8'h30, 8'h12, 8'hE1, 8'h85, 8'hD4, 8'h20, 8'h18, 8'hF7, 8'hAC, 8'h20, 8'h1A,
		8'hFB, 8'h14, 8'h20, 8'h21, 8'h56, 8'h30, 8'h30, 8'h24, 8'h5B, 8'h14, 8'h2C, 8'h20,
		8'h27, 8'h47, 8'hDC, 8'h20, 8'h29, 8'h59, 8'h38, 8'h18, 8'h2B, 8'h32, 8'h80, 8'h28,
		8'h34, 8'hC7, 8'h84, 8'h80, 8'h28, 8'h35, 8'h30, 8'hD8, 8'hA0
	};
	logic [7:0] dir_bytes [pkm_pkg::DIR_ROM_LEN] = '{
		8'h06, 8'h20, 8'h18, 8'h53, 8'h50, 8'h28, 8'h24, 8'h93, 8'hA2, 8'h80, 8'h20, 8'h04,
		8'h11, 8'hAC, 8'h30, 8'h03, 8'h27, 8'hD5, 8'hC4, 8'h10, 8'h2B, 8'h00, 8'h20, 8'h08,
		8'hFB, 8'hB8
	};

	// unpacked keyword tables
	int         kw_count [2];
	logic [4:0] kw_len   [2][MAX_ENT];
	logic [4:0] kw_id    [2][MAX_ENT];
	logic [4:0] kw_text  [2][MAX_ENT][MAX_TOK];

	// matcher state as predicted
	logic               cur_sel      = pkm_pkg::SEL_CMD;
	logic [MAX_ENT-1:0] live_entries = '1;
	int                 tok_pos      = 0;

	pkm_pkg::res_t pending_matches [$];

	int send_idle_pct  = 8;
	int recv_idle_pct  = 50;
	int mismatch_count = 0;
	int char_count     = 0;
	int token_count    = 0;
	int result_count   = 0;
	int switch_count   = 0;
	int cycle_count    = 0;

	// dut ports
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = '0;
	logic        last_char = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [7:0]  entry_index;
	logic [7:0]  entry_id;

	packed_keyword_prefix_matcher_top #(
		.MAX_ENTRIES(MAX_ENT),
		.MAX_TOKEN_LEN(MAX_TOK)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_index(entry_index),
		.entry_id(entry_id)
	);

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	// cycle watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_matches.size());
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP) begin
			$display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
		end
	endtask

	function automatic logic [7:0] dict_byte(input logic t, input int i);
		if (t == pkm_pkg::SEL_DIR) begin
			return (i < pkm_pkg::DIR_ROM_LEN) ? dir_bytes[i] : 8'h00;
		end
		return (i < pkm_pkg::CMD_ROM_LEN) ? cmd_bytes[i] : 8'h00;
	endfunction

	// five bits gathered one at a time, msb first
	function automatic logic [4:0] dict_field(input logic t, input int bitpos);
		logic [4:0] v;
		logic [7:0] b;
		int         p;
		v = '0;
		for (int k = 0; k < 5; k++) begin
			p = bitpos + k;
			b = dict_byte(t, p / 8);
			v = {v[3:0], b[7 - (p % 8)]};
		end
		return v;
	endfunction

	// walk both dictionaries into per-entry length, id and text
	function automatic void load_dictionaries();
		int n;
		int off;
		int bp;
		for (int t = 0; t < 2; t++) begin
			n = int'(dict_byte(t[0], 0));
			if (n > MAX_ENT) n = MAX_ENT;
			kw_count[t] = n;
			off = 1;
			for (int e = 0; e < n; e++) begin
				bp = off * 8;
				kw_len[t][e] = dict_field(t[0], bp);
				kw_id[t][e]  = dict_field(t[0], bp + 5);
				for (int p = 0; p < MAX_TOK; p++) begin
					kw_text[t][e][p] = dict_field(t[0], bp + 10 + 5 * p);
				end
				off = off + (5 * (int'(kw_len[t][e]) + 2) + 7) / 8;
			end
		end
	endfunction

	// one character against the live set; returns 1 when a result is due
	function automatic bit match_step(input logic [7:0] c, input logic lst,
		output pkm_pkg::res_t r);
		int hits;
		int first;
		hits  = 0;
		first = 0;
		r     = NO_BEAT;
		for (int e = 0; e < kw_count[cur_sel]; e++) begin
			if (tok_pos < MAX_TOK) begin
				if (tok_pos >= int'(kw_len[cur_sel][e]) ||
					{3'b000, kw_text[cur_sel][e][tok_pos]} != c) begin
					live_entries[e] = 1'b0;
				end
			end
			if (live_entries[e]) begin
				if (hits == 0) first = e;
				hits++;
			end
		end
		if (tok_pos < MAX_TOK) tok_pos++;
		if (!lst) return 1'b0;
		if (hits == 1) begin
			r.status = pkm_pkg::ST_OK;
			r.index  = first[7:0];
			r.id     = {3'b000, kw_id[cur_sel][first]};
		end else begin
			r = ERR_BEAT;
		end
		live_entries = '1;
		tok_pos      = 0;
		return 1'b1;
	endfunction

	// send one character beat, predict on acceptance
	task automatic send_char(input logic [7:0] c, input logic lst, input logic typed,
		input pkm_pkg::res_t want);
		pkm_pkg::res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= lst;
		do @(posedge clk); while (in_stall);
		char_count++;
		if (match_step(c, lst, r)) begin
			pending_matches.push_back(typed ? want : r);
			token_count++;
		end
	endtask

	// hold the sender until every result is back and the pipe is empty
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (a == SEL_ADDR) cur_sel = d[0];
		switch_count++;
		@(posedge clk);
	endtask

	task automatic reg_readback();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= SEL_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'b0, cur_sel}) begin
			report_mismatch("table_select readback", prdata, {31'b0, cur_sel});
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// mostly keyword prefixes, some with a wrong letter, some noise, a few overlong
	task automatic random_token();
		logic [7:0] tok [$];
		int         e;
		int         k;
		int         r;
		int         span;
		r = $urandom_range(99);
		e = $urandom_range(kw_count[cur_sel] - 1, 0);
		if (r < 80) begin
			k = $urandom_range(kw_len[cur_sel][e], 1);
			if (k == 0) k = 1;
			for (int j = 0; j < k; j++) tok.push_back({3'b000, kw_text[cur_sel][e][j]});
			if (r >= 65) tok[$urandom_range(k - 1, 0)] = 8'($urandom_range(31, 1));
		end else if (r < 95) begin
			span = $urandom_range(5, 1);
			repeat (span) begin
				if ($urandom_range(3) == 0) tok.push_back(8'($urandom_range(254, 1)));
				else tok.push_back(8'($urandom_range(31, 1)));
			end
		end else begin
			span = $urandom_range(MAX_TOK + 8, MAX_TOK + 1);
			for (int j = 0; j < span; j++) begin
				if (j < int'(kw_len[cur_sel][e])) tok.push_back({3'b000, kw_text[cur_sel][e][j]});
				else tok.push_back(8'($urandom_range(31, 1)));
			end
		end
		for (int j = 0; j < tok.size(); j++) begin
			send_char(tok[j], j == tok.size() - 1, 1'b0, NO_BEAT);
		end
	endtask

	// result side: random stall and check against the oldest expectation
	always @(posedge clk) begin : result_check
		pkm_pkg::res_t want;
		out_stall <= ($urandom_range(99) < recv_idle_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (pending_matches.size() == 0) begin
				report_mismatch("result beat with nothing pending",
					{15'b0, status, entry_index, entry_id}, 32'h0);
			end else begin
				want = pending_matches.pop_front();
				result_count++;
				if (status !== want.status) begin
					report_mismatch("status", {31'b0, status}, {31'b0, want.status});
				end
				if (entry_index !== want.index) begin
					report_mismatch("entry_index", {24'b0, entry_index}, {24'b0, want.index});
				end
				if (entry_id !== want.id) begin
					report_mismatch("entry_id", {24'b0, entry_id}, {24'b0, want.id});
				end
			end
		end
	end

	// main sequence
	initial begin : stimulus
		stim_row_t  row;
		int         phase_end;
		logic [2:0] a;
		load_dictionaries();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			case (row.kind)
				ROW_CHAR: begin
					send_char(row.code, row.lst, row.typed, row.want);
				end
				ROW_CFG: begin
					wait_idle();
					reg_write(SEL_ADDR, {24'b0, row.code});
					reg_readback();
				end
				default: begin
					wait_idle();
					reg_write(BAD_ADDR, {24'b0, row.code});
					reg_readback();
				end
			endcase
		end

		// random phases with different idle mixes
		for (int ph = 0; ph < 3; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 50;
					reg_write(SEL_ADDR, {31'b0, pkm_pkg::SEL_CMD});
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 8;
					reg_write(SEL_ADDR, {31'b0, pkm_pkg::SEL_DIR});
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					reg_write(SEL_ADDR, $urandom());
				end
			endcase
			reg_readback();
			phase_end = char_count + PHASE_CHARS;
			while (char_count < phase_end) begin
				// occasional table_select write between tokens, sometimes past the register map
				if ($urandom_range(29) == 0) begin
					wait_idle();
					a = ($urandom_range(3) == 0) ? BAD_ADDR : SEL_ADDR;
					reg_write(a, $urandom());
					reg_readback();
				end
				random_token();
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("run covered %0d characters, %0d tokens, %0d results checked",
			char_count, token_count, result_count);
		$display("both keyword tables, %0d register writes, three sender/receiver idle mixes",
			switch_count);
		if (mismatch_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
